/* hdl/ubfp_pkg.sv */
// package: shared types and constants for the uart buffered fifo pair
package ubfp_pkg;

  localparam int DEF_RX_DEPTH = 64;
  localparam int DEF_TX_DEPTH = 64;

  localparam int CMD_W = 3;
  localparam int DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_RX_BYTE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TX_READY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TX_DONE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP      = 3'd4;

  typedef struct packed {
    logic exec;
    logic load;
  } ctrl_t;

endpackage

/* hdl/uart_buffered_fifo_pair.sv */
// top level: uart buffered fifo pair with request and result channels
//
// usage: each request on the in_valid / in_ready channel is one line event or
// host access (byte received, transmitter ready, transmit complete, host push,
// host pop). every request gives exactly one result on the result_valid /
// result_ready channel, carrying the popped or outgoing byte and the ring and
// transmit status after that request.
// a request is executed when taken, its byte read into the registered ring
// store output; its result enters the output register once that is free.
// a new request is taken only once the previous result has been loaded into
// the output register.
// each ring holds one byte less than its depth.
// reset: indices clear, both rings read empty, the finished flag is set, the
// send request and completion wait flags clear, no result is held.
// stall: while result_ready is low the result is held; one further request
// may be taken and executed, then in_ready stays low until the held result
// is taken.
module uart_buffered_fifo_pair
  import ubfp_pkg::*;
#(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [DATA_W-1:0] data,
  input  logic              frame_error,
  input  logic              overrun_error,
  input  logic              parity_error,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [DATA_W-1:0] out_data,
  output logic              out_valid,
  output logic              accepted,
  output logic              rx_has_data,
  output logic              tx_full,
  output logic              tx_empty,
  output logic              tx_finished,
  output logic              send_request,
  output logic              complete_wait
);

  ctrl_t ctrl;

  ubfp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .ctrl         (ctrl)
  );

  ubfp_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .command       (command),
    .data          (data),
    .frame_error   (frame_error),
    .overrun_error (overrun_error),
    .parity_error  (parity_error),
    .out_data      (out_data),
    .out_valid     (out_valid),
    .accepted      (accepted),
    .rx_has_data   (rx_has_data),
    .tx_full       (tx_full),
    .tx_empty      (tx_empty),
    .tx_finished   (tx_finished),
    .send_request  (send_request),
    .complete_wait (complete_wait)
  );

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one still executing");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !out_valid) |-> (out_data == '0))
    else $error("result byte not zero without a byte");

  a_finished_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && tx_finished) |-> tx_empty)
    else $error("transmit finished reported with bytes queued");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(tx_full && tx_empty))
    else $error("transmit ring both full and empty");
`endif

endmodule

/* hdl/ubfp_ctrl.sv */
// controller: request sequencing and result register handshake
module ubfp_ctrl
  import ubfp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  result_valid,
  input  logic  result_ready,
  output ctrl_t ctrl
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_RESULT = 1'b1;

  logic state;
  logic state_next;
  logic result_valid_next;

  always_comb begin
    in_ready = (state == S_IDLE);
    ctrl.exec = in_valid && in_ready;
    ctrl.load = (state == S_RESULT) && (!result_valid || result_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctrl.exec) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (ctrl.load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (ctrl.load) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

/* hdl/ubfp_dp.sv */
// datapath: receive and transmit rings, flags and result register
module ubfp_dp
  import ubfp_pkg::*;
#(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             ctrl,
  input  logic [CMD_W-1:0]  command,
  input  logic [DATA_W-1:0] data,
  input  logic              frame_error,
  input  logic              overrun_error,
  input  logic              parity_error,
  output logic [DATA_W-1:0] out_data,
  output logic              out_valid,
  output logic              accepted,
  output logic              rx_has_data,
  output logic              tx_full,
  output logic              tx_empty,
  output logic              tx_finished,
  output logic              send_request,
  output logic              complete_wait
);

  localparam int RX_IW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_IW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RX_IW-1:0] RX_LAST = RX_IW'(RX_DEPTH - 1);
  localparam logic [TX_IW-1:0] TX_LAST = TX_IW'(TX_DEPTH - 1);

  logic [DATA_W-1:0] rx_mem [RX_DEPTH];
  logic [DATA_W-1:0] tx_mem [TX_DEPTH];
  logic [DATA_W-1:0] rx_q;
  logic [DATA_W-1:0] tx_q;

  logic [RX_IW-1:0] rx_wr, rx_rd, rx_wr_next, rx_rd_next, rx_wr_adv, rx_rd_adv;
  logic [TX_IW-1:0] tx_wr, tx_rd, tx_wr_next, tx_rd_next, tx_wr_adv, tx_rd_adv;
  logic finished, finished_next;
  logic send_req, send_req_next;
  logic cwait, cwait_next;

  logic pend_valid, pend_valid_next;
  logic pend_acc, pend_acc_next;
  logic pend_tx, pend_tx_next;

  logic rx_we, rx_re, tx_we, tx_re;
  logic err;

  // ring index advance with wrap
  always_comb begin
    rx_wr_adv = (rx_wr == RX_LAST) ? '0 : rx_wr + 1'b1;
    rx_rd_adv = (rx_rd == RX_LAST) ? '0 : rx_rd + 1'b1;
    tx_wr_adv = (tx_wr == TX_LAST) ? '0 : tx_wr + 1'b1;
    tx_rd_adv = (tx_rd == TX_LAST) ? '0 : tx_rd + 1'b1;
    err = frame_error | overrun_error | parity_error;
  end

  // command decode
  always_comb begin
    rx_wr_next = rx_wr;
    rx_rd_next = rx_rd;
    tx_wr_next = tx_wr;
    tx_rd_next = tx_rd;
    finished_next = finished;
    send_req_next = send_req;
    cwait_next = cwait;
    pend_valid_next = 1'b0;
    pend_acc_next = 1'b0;
    pend_tx_next = 1'b0;
    rx_we = 1'b0;
    rx_re = 1'b0;
    tx_we = 1'b0;
    tx_re = 1'b0;
    unique case (command)
      CMD_RX_BYTE: begin
        if (rx_wr_adv != rx_rd && !err) begin
          rx_we = ctrl.exec;
          rx_wr_next = rx_wr_adv;
          pend_acc_next = 1'b1;
        end
      end
      CMD_TX_READY: begin
        pend_tx_next = 1'b1;
        if (tx_rd == tx_wr) begin
          send_req_next = 1'b0;
          cwait_next = 1'b1;
        end else begin
          finished_next = 1'b0;
          tx_re = ctrl.exec;
          tx_rd_next = tx_rd_adv;
          pend_valid_next = 1'b1;
        end
      end
      CMD_TX_DONE: begin
        finished_next = 1'b1;
        cwait_next = 1'b0;
      end
      CMD_PUSH: begin
        if (tx_wr_adv != tx_rd) begin
          tx_we = ctrl.exec;
          tx_wr_next = tx_wr_adv;
          send_req_next = 1'b1;
          pend_acc_next = 1'b1;
        end
      end
      CMD_POP: begin
        if (rx_rd != rx_wr) begin
          rx_re = ctrl.exec;
          rx_rd_next = rx_rd_adv;
          pend_valid_next = 1'b1;
        end
      end
      default: begin
        pend_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wr <= '0;
      rx_rd <= '0;
      tx_wr <= '0;
      tx_rd <= '0;
      finished <= 1'b1;
      send_req <= 1'b0;
      cwait <= 1'b0;
    end else if (ctrl.exec) begin
      rx_wr <= rx_wr_next;
      rx_rd <= rx_rd_next;
      tx_wr <= tx_wr_next;
      tx_rd <= tx_rd_next;
      finished <= finished_next;
      send_req <= send_req_next;
      cwait <= cwait_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      pend_valid <= pend_valid_next;
      pend_acc <= pend_acc_next;
      pend_tx <= pend_tx_next;
    end
  end

  // receive ring store
  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_wr] <= data;
    if (rx_re) rx_q <= rx_mem[rx_rd];
  end

  // transmit ring store
  always_ff @(posedge clk) begin
    if (tx_we) tx_mem[tx_wr] <= data;
    if (tx_re) tx_q <= tx_mem[tx_rd];
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_data <= pend_valid ? (pend_tx ? tx_q : rx_q) : '0;
      out_valid <= pend_valid;
      accepted <= pend_acc;
      rx_has_data <= (rx_rd != rx_wr);
      tx_full <= (tx_wr_adv == tx_rd);
      tx_empty <= (tx_rd == tx_wr);
      tx_finished <= (tx_rd == tx_wr) && finished;
      send_request <= send_req;
      complete_wait <= cwait;
    end
  end

endmodule
